// ----- rtl/core/fpwc_pkg.sv -----
// Shared constants and types for the flash page write combiner.
// Depends on nothing; imported by rtl/core/flash_page_write_combiner.sv.
package fpwc_pkg;

	localparam int ADDR_W       = 24;
	localparam int BYTE_W       = 8;
	localparam int WORD_BYTES   = 8;
	localparam int WORD_W       = WORD_BYTES * BYTE_W;
	localparam int PAGE_BYTES   = 256;
	localparam int SECTOR_BYTES = 4096;
	localparam int PAGE_WORDS   = PAGE_BYTES / WORD_BYTES;
	localparam int PAGE_W       = $clog2(PAGE_BYTES);
	localparam int SECTOR_W     = $clog2(SECTOR_BYTES);
	localparam int LANE_W       = $clog2(WORD_BYTES);
	localparam int ROW_W        = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;

	localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_FLUSH  = 1'b1;
	localparam logic CMD_ERASE   = 1'b0;
	localparam logic CMD_PROGRAM = 1'b1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [LANE_W-1:0] lane_t;

endpackage

// ----- rtl/core/flash_page_write_combiner.sv -----
// Flash page write combiner: byte writes gathered in one page buffer memory,
// issued as sector erase and 64-bit program word commands.
// Depends on fpwc_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall): kind, offset, data_byte. A write
//   lands at area_base + offset (24-bit wrap); a flush drains the page.
//   Output channel (out_valid/out_stall): command, flash_address,
//   word_data, last, held in an output register.
//   Config channel (cfg_valid/cfg_ready/cfg_data) writes area_base; always
//   ready; the user is to write it only while the block is idle (not enforced).
// Throughput and stalls:
//   A plain byte write that stays in the buffered page is stored in the
//   cycle it is accepted, one item per cycle while input is not stalled.
//   A sector-start byte stalls input while the erase command is loaded
//   (ERASE state) and then while the byte is stored (WRITE state).
//   A change of page while dirty runs a flush, then stores the byte in the
//   WRITE state; a byte in the last page position runs a flush once stored.
//   A flush reads the page memory through one registered read port and emits
//   one word per cycle when unstalled; input is stalled for the whole flush.
// Reset: area_base is zero, the buffer reads as all 0xFF, clean, page 0.
// Output stall: the output register holds its command and the flush read
//   pipeline stops until the receiver takes it.
module flash_page_write_combiner (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  fpwc_pkg::addr_t       cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  kind,
	input  fpwc_pkg::addr_t       offset,
	input  fpwc_pkg::byte_t       data_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  command,
	output fpwc_pkg::addr_t       flash_address,
	output fpwc_pkg::word_t       word_data,
	output logic                  last
);
	import fpwc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ERASE = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;
	addr_t      area_base_q;
	addr_t      buf_page_q;
	logic       dirty_q;
	logic       ret_write_q;
	logic       pre_flush_q;
	addr_t      req_addr_q;
	byte_t      req_data_q;
	logic [PAGE_WORDS-1:0] row_valid_q;

	word_t      page_mem [PAGE_WORDS];
	word_t      rd_data_s1;
	logic       rd_row_valid_s1;
	logic       rd_valid_s1;
	row_t       rd_idx_s1;
	row_t       rd_idx_q;
	logic       rd_done_q;

	logic       out_valid_q;
	logic       out_command_q;
	addr_t      out_addr_q;
	word_t      out_word_q;
	logic       out_last_q;

	logic       in_accept;
	logic       out_free;
	addr_t      addr_c;
	logic       sector_start_c;
	logic       pre_flush_c;
	addr_t      wr_addr;
	byte_t      wr_data;
	addr_t      wr_page;
	row_t       wr_row;
	lane_t      wr_lane;
	logic       wr_full;
	logic       wr_post;
	word_t      wr_word;
	logic       mem_we;
	logic       mem_re;
	logic       load_erase;
	logic       load_word;
	logic       flush_end;
	word_t      rd_word;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign addr_c         = area_base_q + offset;
	assign sector_start_c = (addr_c[SECTOR_W-1:0] == '0);
	assign pre_flush_c    = dirty_q &&
		((addr_c & ~addr_t'(PAGE_BYTES - 1)) != buf_page_q);

	// Write source: straight from the input when idle, else the held request.
	always_comb begin
		wr_addr = (state_q == ST_IDLE) ? addr_c : req_addr_q;
		wr_data = (state_q == ST_IDLE) ? data_byte : req_data_q;
		wr_page = wr_addr & ~addr_t'(PAGE_BYTES - 1);
		wr_row  = row_t'(wr_addr[PAGE_W-1:0] >> LANE_W);
		wr_lane = wr_addr[LANE_W-1:0];
		wr_full = !row_valid_q[wr_row];
		wr_post = (wr_addr[PAGE_W-1:0] == PAGE_W'(PAGE_BYTES - 1));
		for (int i = 0; i < WORD_BYTES; i++) begin
			wr_word[i*BYTE_W +: BYTE_W] = (lane_t'(i) == wr_lane) ? wr_data : ERASED_BYTE;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		if (state_q == ST_WRITE) begin
			mem_we = 1'b1;
		end else if (in_accept && kind == KIND_WRITE && !sector_start_c && !pre_flush_c) begin
			mem_we = 1'b1;
		end
	end

	assign load_erase = (state_q == ST_ERASE) && out_free;
	assign load_word  = (state_q == ST_FLUSH) && rd_valid_s1 && out_free;
	assign flush_end  = load_word && (rd_idx_s1 == row_t'(PAGE_WORDS - 1));
	assign mem_re     = (state_q == ST_FLUSH) && !rd_done_q && (!rd_valid_s1 || load_word);
	assign rd_word    = rd_row_valid_s1 ? rd_data_s1 : {WORD_BYTES{ERASED_BYTE}};

	// Page memory: one write port with byte lanes, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			if (wr_full) begin
				page_mem[wr_row] <= wr_word;
			end else begin
				page_mem[wr_row][{wr_lane, {LANE_W{1'b0}}} +: BYTE_W] <= wr_data;
			end
		end
		if (mem_re) begin
			rd_data_s1 <= page_mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_row_valid_s1 <= row_valid_q[rd_idx_q];
			rd_idx_s1       <= rd_idx_q;
		end
		if (in_accept) begin
			req_addr_q  <= addr_c;
			req_data_q  <= data_byte;
			pre_flush_q <= pre_flush_c;
		end
		if (load_erase) begin
			out_command_q <= CMD_ERASE;
			out_addr_q    <= req_addr_q;
			out_word_q    <= '0;
			out_last_q    <= 1'b1;
		end else if (load_word) begin
			out_command_q <= CMD_PROGRAM;
			out_addr_q    <= buf_page_q + ADDR_W'({rd_idx_s1, {LANE_W{1'b0}}});
			out_word_q    <= rd_word;
			out_last_q    <= (rd_idx_s1 == row_t'(PAGE_WORDS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			area_base_q <= '0;
			buf_page_q  <= '0;
			dirty_q     <= 1'b0;
			ret_write_q <= 1'b0;
			row_valid_q <= '0;
			rd_valid_s1 <= 1'b0;
			rd_idx_q    <= '0;
			rd_done_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				area_base_q <= cfg_data;
			end

			if (mem_we) begin
				row_valid_q[wr_row] <= 1'b1;
				buf_page_q          <= wr_page;
				dirty_q             <= 1'b1;
			end

			// Flush read pipeline: advance one word whenever the stage frees.
			if (state_q != ST_FLUSH) begin
				rd_idx_q  <= '0;
				rd_done_q <= 1'b0;
			end else if (mem_re) begin
				rd_idx_q <= rd_idx_q + row_t'(1);
				if (rd_idx_q == row_t'(PAGE_WORDS - 1)) begin
					rd_done_q <= 1'b1;
				end
			end
			if (mem_re) begin
				rd_valid_s1 <= 1'b1;
			end else if (load_word) begin
				rd_valid_s1 <= 1'b0;
			end

			if (load_erase || load_word) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (kind == KIND_FLUSH) begin
							if (dirty_q) begin
								state_q     <= ST_FLUSH;
								ret_write_q <= 1'b0;
							end
						end else if (sector_start_c) begin
							state_q <= ST_ERASE;
						end else if (pre_flush_c) begin
							state_q     <= ST_FLUSH;
							ret_write_q <= 1'b1;
						end else if (wr_post) begin
							state_q     <= ST_FLUSH;
							ret_write_q <= 1'b0;
						end
					end
				end
				ST_ERASE: begin
					if (load_erase) begin
						if (pre_flush_q) begin
							state_q     <= ST_FLUSH;
							ret_write_q <= 1'b1;
						end else begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					if (wr_post) begin
						state_q     <= ST_FLUSH;
						ret_write_q <= 1'b0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					// Drop the whole page back to erased once the last word leaves.
					if (flush_end) begin
						row_valid_q <= '0;
						dirty_q     <= 1'b0;
						state_q     <= ret_write_q ? ST_WRITE : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign command       = out_command_q;
	assign flash_address = out_addr_q;
	assign word_data     = out_word_q;
	assign last          = out_last_q;

	a_no_write_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> !mem_we)
		else $error("page memory written during flush");

	a_flush_only_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> dirty_q)
		else $error("flush running on a clean buffer");

	a_flush_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		flush_end |=> (!dirty_q && row_valid_q == '0))
		else $error("buffer not cleared after flush");

	a_read_stage_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == ST_FLUSH))
		else $error("read data pending outside flush");

endmodule
